FILE: rtl/core/lfsc_pkg.sv
// ----------------------------------------------------------------------------
// lfsc_pkg
// shared types and constants of the line-follow steering controller
// ----------------------------------------------------------------------------
package lfsc_pkg;

  localparam int unsigned SENSOR_COUNT = 8;
  localparam int unsigned SAMPLE_W     = 10;
  localparam int unsigned POS_W        = 13;
  localparam int unsigned WSUM_W       = 25;  // 1023 * 28 * 1000 < 2^25
  localparam int unsigned SUM_W        = 13;  // 8 * 1023 < 2^13
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned DIV_STEPS    = WSUM_W;

  // configuration register indexes
  localparam logic [2:0] CFG_NOISE_LEVEL  = 3'd0;
  localparam logic [2:0] CFG_PIVOT_LEFT   = 3'd1;
  localparam logic [2:0] CFG_CURVE_LEFT   = 3'd2;
  localparam logic [2:0] CFG_CENTER_LEFT  = 3'd3;
  localparam logic [2:0] CFG_CENTER_RIGHT = 3'd4;
  localparam logic [2:0] CFG_CURVE_RIGHT  = 3'd5;
  localparam logic [2:0] CFG_PIVOT_RIGHT  = 3'd6;
  localparam logic [2:0] CFG_COAST_TICKS  = 3'd7;

  // motor direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  // positions and drive levels
  localparam logic [POS_W-1:0] POS_LEFT   = 13'd0;
  localparam logic [POS_W-1:0] POS_CENTRE = 13'd3500;
  localparam logic [POS_W-1:0] POS_RIGHT  = 13'd7000;
  localparam logic [3:0]       SNAP_COUNT = 4'd5;

  localparam logic [7:0] SPD_ZERO   = 8'd0;
  localparam logic [7:0] SPD_CRUISE = 8'd100;
  localparam logic [7:0] SPD_SOFT   = 8'd115;
  localparam logic [7:0] SPD_SLOW   = 8'd85;
  localparam logic [7:0] SPD_PIVOT  = 8'd200;
  localparam logic [7:0] SPD_BACK   = 8'd95;
  localparam logic [7:0] SPD_CURVE  = 8'd170;
  localparam logic [7:0] SPD_INNER  = 8'd70;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample0;
    logic [SAMPLE_W-1:0] sample1;
    logic [SAMPLE_W-1:0] sample2;
    logic [SAMPLE_W-1:0] sample3;
    logic [SAMPLE_W-1:0] sample4;
    logic [SAMPLE_W-1:0] sample5;
    logic [SAMPLE_W-1:0] sample6;
    logic [SAMPLE_W-1:0] sample7;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       left_dir;
    logic [7:0]       left_speed;
    logic [1:0]       right_dir;
    logic [7:0]       right_speed;
    logic [POS_W-1:0] line_position;
    logic             line_seen;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       scan;
    logic [2:0] idx;
    logic       div_step;
    logic       finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic use_div;
  } status_t;

  // sensor weight, index times 1000
  function automatic logic [POS_W-1:0] sensor_weight(input logic [2:0] idx);
    logic [POS_W-1:0] w;
    unique case (idx)
      3'd0: w = 13'd0;
      3'd1: w = 13'd1000;
      3'd2: w = 13'd2000;
      3'd3: w = 13'd3000;
      3'd4: w = 13'd4000;
      3'd5: w = 13'd5000;
      3'd6: w = 13'd6000;
      3'd7: w = 13'd7000;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/lfsc_ctrl.sv
// ----------------------------------------------------------------------------
// lfsc_ctrl
// sequencer: scan sweep, divide steps, result hand-off
// ----------------------------------------------------------------------------
module lfsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  lfsc_pkg::status_t status_i,
  output lfsc_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  localparam logic [lfsc_pkg::CNT_W-1:0] ScanLast =
    lfsc_pkg::CNT_W'(lfsc_pkg::SENSOR_COUNT - 1);
  localparam logic [lfsc_pkg::CNT_W-1:0] DivLast =
    lfsc_pkg::CNT_W'(lfsc_pkg::DIV_STEPS - 1);

  state_e                     state_q;
  logic [lfsc_pkg::CNT_W-1:0] cnt_q;
  logic                       out_valid_q;
  logic                       slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.idx      = cnt_q[2:0];
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.scan     = (state_q == ST_SCAN);
    cmd_o.div_step = (state_q == ST_DIVIDE) && status_i.use_div;
    cmd_o.finish   = (state_q == ST_FINISH) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // taken result leaves unless a new one replaces it this cycle
      if (out_valid_q && !out_stall_i && !cmd_o.finish) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SCAN;
            cnt_q   <= '0;
          end
        end
        ST_SCAN: begin
          if (cnt_q == ScanLast) begin
            state_q <= ST_DIVIDE;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DIVIDE: begin
          // no divide for a snapped position or a lost line
          if (!status_i.use_div || cnt_q == DivLast) begin
            state_q <= ST_FINISH;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
          end
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_SCAN && cnt_q == '0))
    else $error("accepted item did not start a scan");

  a_div_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) |-> (cnt_q <= DivLast))
    else $error("divide step count out of range");

  a_finish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("finished result not presented");
`endif

endmodule

FILE: rtl/core/lfsc_datapath.sv
// ----------------------------------------------------------------------------
// lfsc_datapath
// sample accumulation, restoring divider, drive band selection, state
// ----------------------------------------------------------------------------
module lfsc_datapath #(
  parameter int unsigned SWEEP_TICKS = 800
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  lfsc_pkg::in_item_t  in_item_i,
  input  lfsc_pkg::cmd_t      cmd_i,
  output lfsc_pkg::status_t   status_o,
  output lfsc_pkg::out_item_t out_item_o
);

  localparam int unsigned PW = lfsc_pkg::POS_W;
  localparam int unsigned SW = lfsc_pkg::SAMPLE_W;
  localparam logic [15:0] SweepLim  = 16'(SWEEP_TICKS);
  localparam logic [15:0] SweepLim2 = 16'(2 * SWEEP_TICKS);

  // configuration
  logic [SW-1:0] noise_q;
  logic [PW-1:0] pivot_l_q, curve_l_q, centre_l_q, centre_r_q, curve_r_q, pivot_r_q;
  logic [15:0]   coast_q;

  // state kept between items
  logic [PW-1:0] last_pos_q;
  logic [15:0]   gap_q;

  // per item working registers
  logic [SW-1:0]                 smp_q [lfsc_pkg::SENSOR_COUNT];
  logic [lfsc_pkg::WSUM_W-1:0]   wsum_q;   // also holds the quotient
  logic [lfsc_pkg::SUM_W-1:0]    sum_q;
  logic [lfsc_pkg::SUM_W-1:0]    rem_q;
  logic [3:0]                    act_cnt_q;
  logic                          edge_l_q, edge_r_q;
  lfsc_pkg::out_item_t           out_q;

  logic                          head_act;
  logic [22:0]                   prod;
  logic [lfsc_pkg::SUM_W:0]      part, trial;
  logic                          q_bit;
  logic                          seen;
  logic [PW-1:0]                 pos;
  logic [15:0]                   gap_inc;
  lfsc_pkg::out_item_t           res;

  assign head_act = smp_q[0] > noise_q;
  assign prod     = 23'(smp_q[0]) * 23'(lfsc_pkg::sensor_weight(cmd_i.idx));

  // one quotient bit a step
  assign part  = {rem_q, wsum_q[lfsc_pkg::WSUM_W-1]};
  assign q_bit = part >= {1'b0, sum_q};
  assign trial = part - {1'b0, sum_q};

  assign seen              = (act_cnt_q != 4'd0);
  assign status_o.use_div  = seen && (act_cnt_q < lfsc_pkg::SNAP_COUNT);

  always_comb begin
    if (act_cnt_q >= lfsc_pkg::SNAP_COUNT) begin
      pos = edge_l_q ? lfsc_pkg::POS_LEFT
          : (edge_r_q ? lfsc_pkg::POS_RIGHT : lfsc_pkg::POS_CENTRE);
    end else begin
      pos = wsum_q[PW-1:0];
    end
  end

  assign gap_inc = (gap_q == 16'hFFFF) ? gap_q : gap_q + 16'd1;

  always_comb begin
    res           = '0;
    res.line_seen = seen;
    res.left_dir  = lfsc_pkg::DIR_FWD;
    res.right_dir = lfsc_pkg::DIR_FWD;
    if (seen) begin
      res.line_position = pos;
      priority if (pos < pivot_l_q) begin
        res.left_dir    = lfsc_pkg::DIR_REV;
        res.left_speed  = lfsc_pkg::SPD_BACK;
        res.right_speed = lfsc_pkg::SPD_PIVOT;
      end else if (pos < curve_l_q) begin
        res.left_speed  = lfsc_pkg::SPD_INNER;
        res.right_speed = lfsc_pkg::SPD_CURVE;
      end else if (pos < centre_l_q) begin
        res.left_speed  = lfsc_pkg::SPD_SLOW;
        res.right_speed = lfsc_pkg::SPD_SOFT;
      end else if (pos > pivot_r_q) begin
        res.right_dir   = lfsc_pkg::DIR_REV;
        res.left_speed  = lfsc_pkg::SPD_PIVOT;
        res.right_speed = lfsc_pkg::SPD_BACK;
      end else if (pos > curve_r_q) begin
        res.left_speed  = lfsc_pkg::SPD_CURVE;
        res.right_speed = lfsc_pkg::SPD_INNER;
      end else if (pos > centre_r_q) begin
        res.left_speed  = lfsc_pkg::SPD_SOFT;
        res.right_speed = lfsc_pkg::SPD_SLOW;
      end else begin
        res.left_speed  = lfsc_pkg::SPD_CRUISE;
        res.right_speed = lfsc_pkg::SPD_CRUISE;
      end
    end else begin
      res.line_position = last_pos_q;
      priority if (gap_inc < coast_q) begin
        if (last_pos_q > curve_l_q && last_pos_q < curve_r_q) begin
          res.left_speed  = lfsc_pkg::SPD_CRUISE;
          res.right_speed = lfsc_pkg::SPD_CRUISE;
        end else if (last_pos_q <= curve_l_q) begin
          res.left_speed  = lfsc_pkg::SPD_ZERO;
          res.right_speed = lfsc_pkg::SPD_CURVE;
        end else begin
          res.left_speed  = lfsc_pkg::SPD_CURVE;
          res.right_speed = lfsc_pkg::SPD_ZERO;
        end
      end else if (gap_inc < SweepLim2) begin
        // first sweep toward the last side, then back the other way
        if ((last_pos_q >= lfsc_pkg::POS_CENTRE) == (gap_inc < SweepLim)) begin
          res.right_dir   = lfsc_pkg::DIR_REV;
          res.left_speed  = lfsc_pkg::SPD_PIVOT;
          res.right_speed = lfsc_pkg::SPD_BACK;
        end else begin
          res.left_dir    = lfsc_pkg::DIR_REV;
          res.left_speed  = lfsc_pkg::SPD_BACK;
          res.right_speed = lfsc_pkg::SPD_PIVOT;
        end
      end else begin
        res.left_dir  = lfsc_pkg::DIR_STOP;
        res.right_dir = lfsc_pkg::DIR_STOP;
      end
    end
  end

  // configuration and persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q    <= 10'd300;
      pivot_l_q  <= 13'd1200;
      curve_l_q  <= 13'd2400;
      centre_l_q <= 13'd3050;
      centre_r_q <= 13'd3950;
      curve_r_q  <= 13'd4600;
      pivot_r_q  <= 13'd5800;
      coast_q    <= 16'd300;
      last_pos_q <= lfsc_pkg::POS_CENTRE;
      gap_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lfsc_pkg::CFG_NOISE_LEVEL:  noise_q    <= cfg_wdata_i[SW-1:0];
          lfsc_pkg::CFG_PIVOT_LEFT:   pivot_l_q  <= cfg_wdata_i[PW-1:0];
          lfsc_pkg::CFG_CURVE_LEFT:   curve_l_q  <= cfg_wdata_i[PW-1:0];
          lfsc_pkg::CFG_CENTER_LEFT:  centre_l_q <= cfg_wdata_i[PW-1:0];
          lfsc_pkg::CFG_CENTER_RIGHT: centre_r_q <= cfg_wdata_i[PW-1:0];
          lfsc_pkg::CFG_CURVE_RIGHT:  curve_r_q  <= cfg_wdata_i[PW-1:0];
          lfsc_pkg::CFG_PIVOT_RIGHT:  pivot_r_q  <= cfg_wdata_i[PW-1:0];
          lfsc_pkg::CFG_COAST_TICKS:  coast_q    <= cfg_wdata_i;
        endcase
      end
      if (cmd_i.finish) begin
        if (seen) begin
          last_pos_q <= pos;
          gap_q      <= '0;
        end else begin
          gap_q <= gap_inc;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      smp_q[0]  <= in_item_i.sample0;
      smp_q[1]  <= in_item_i.sample1;
      smp_q[2]  <= in_item_i.sample2;
      smp_q[3]  <= in_item_i.sample3;
      smp_q[4]  <= in_item_i.sample4;
      smp_q[5]  <= in_item_i.sample5;
      smp_q[6]  <= in_item_i.sample6;
      smp_q[7]  <= in_item_i.sample7;
      wsum_q    <= '0;
      sum_q     <= '0;
      rem_q     <= '0;
      act_cnt_q <= '0;
      edge_l_q  <= 1'b0;
      edge_r_q  <= 1'b0;
    end else if (cmd_i.scan) begin
      for (int i = 0; i < lfsc_pkg::SENSOR_COUNT - 1; i++) begin
        smp_q[i] <= smp_q[i+1];
      end
      if (head_act) begin
        wsum_q    <= wsum_q + lfsc_pkg::WSUM_W'(prod);
        sum_q     <= sum_q + lfsc_pkg::SUM_W'(smp_q[0]);
        act_cnt_q <= act_cnt_q + 4'd1;
        if (cmd_i.idx == 3'd0) begin
          edge_l_q <= 1'b1;
        end
        if (cmd_i.idx == 3'(lfsc_pkg::SENSOR_COUNT - 1)) begin
          edge_r_q <= 1'b1;
        end
      end
    end else if (cmd_i.div_step) begin
      rem_q  <= q_bit ? trial[lfsc_pkg::SUM_W-1:0] : part[lfsc_pkg::SUM_W-1:0];
      wsum_q <= {wsum_q[lfsc_pkg::WSUM_W-2:0], q_bit};
    end
    if (cmd_i.finish) begin
      out_q <= res;
    end
  end

  assign out_item_o = out_q;

`ifndef ASSERT_OFF
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> (rem_q < sum_q))
    else $error("divider remainder not below divisor");

  a_last_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_pos_q <= lfsc_pkg::POS_RIGHT)
    else $error("held line position out of range");
`endif

endmodule

FILE: rtl/core/line_follow_steering_controller_core.sv
// sequence: load, sensor scan, divide, hand-off; the divide is skipped when the
// position snaps or the line is lost, and a stalled pending result holds the hand-off
// the sensor scan and the 25-step restoring divider share one sequencer, so a
// new item is taken only once the previous one has been handed off
// reset: asynchronous active low; thresholds return to defaults, held position
// to centre, gap counter to zero, no result pending
// ----------------------------------------------------------------------------
// line_follow_steering_controller_core
// ir line sensor scan to differential drive command, one result per item
// ----------------------------------------------------------------------------
module line_follow_steering_controller_core #(
  parameter int unsigned SWEEP_TICKS = 800
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  // scan items in
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lfsc_pkg::in_item_t  in_item_i,
  // drive items out
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lfsc_pkg::out_item_t out_item_o
);

  // command and status between sequencer and datapath
  lfsc_pkg::cmd_t    cmd;
  lfsc_pkg::status_t status;

  // sequencer: idle, scan of the eight samples, divide, hand-off into the
  // output register; a new item is taken as soon as the sequencer is idle,
  // even while the previous result still waits in the output register
  lfsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: one sensor a cycle is thresholded and accumulated (sample times
  // index weight), the quotient is then built one bit a cycle when the divide is needed, and the final
  // cycle picks the drive band or the lost-line phase from the gap counter
  lfsc_datapath #(
    .SWEEP_TICKS (SWEEP_TICKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item_o)
  );

endmodule
